>>> sv/matrix4_inverse_unit_assert.svh
// Assertion macros for the 4x4 matrix inverse unit.
`ifndef MATRIX4_INVERSE_UNIT_ASSERT_SVH
`define MATRIX4_INVERSE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define M4INV_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("m4inv check failed");
`define M4INV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("m4inv check failed");
`else
`define M4INV_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define M4INV_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> sv/m4inv_pkg.sv
// Types and constants shared by the 4x4 matrix inverse unit.
`default_nettype none
package m4inv_pkg;
    localparam int FRAC_BITS = 16;
    localparam int IW  = 4;                   // element index width
    localparam int EW  = 32;                  // element width
    localparam int CW  = 3 * EW + 2;          // signed cofactor width
    localparam int AW  = 4 * EW + 3;          // accumulator / determinant width
    localparam int QW  = EW + 1;              // quotient bits developed
    localparam int NW  = CW - 1 + 2 * FRAC_BITS; // dividend magnitude width
    localparam int NHW = NW - QW;             // dividend bits above the quotient
    localparam int MCW = $clog2(EW);
    localparam int DCW = $clog2(QW);

    typedef struct packed {
        logic [IW-1:0]        load_index;
        logic signed [EW-1:0] load_value;
        logic                 start_inverse;
    } load_t;

    typedef struct packed {
        logic [IW-1:0]        result_index;
        logic signed [EW-1:0] result_value;
        logic                 singular;
        logic                 saturated;
        logic                 last_result;
    } result_t;

    typedef struct packed {
        logic start;
        logic keep;
        logic neg;
    } mac_cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_X,
        ST_RD_Y,
        ST_LD_Y,
        ST_MUL,
        ST_DET_CHK,
        ST_DIV_RD,
        ST_DIV_GO,
        ST_DIV_RUN,
        ST_EMIT
    } state_t;
endpackage
`default_nettype wire

>>> sv/m4inv_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module m4inv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

>>> sv/m4inv_mac.sv
// Bit-serial signed multiply-accumulate: acc +/- x * y, one multiplier bit per cycle.
`default_nettype none
module m4inv_mac (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire m4inv_pkg::mac_cmd_t         cmd,
    input  wire logic [m4inv_pkg::AW-1:0]    x,
    input  wire logic [m4inv_pkg::EW-1:0]    y,
    input  wire logic [m4inv_pkg::AW-1:0]    init,
    output logic                             busy,
    output logic      [m4inv_pkg::AW-1:0]    acc
);
    logic                         busy_reg, busy_next;
    logic [m4inv_pkg::MCW-1:0]    cnt_reg, cnt_next;
    logic [m4inv_pkg::AW-1:0]     acc_reg, acc_next;
    logic [m4inv_pkg::AW-1:0]     mcand_reg, mcand_next;
    logic [m4inv_pkg::EW-1:0]     y_reg, y_next;
    logic                         neg_reg, neg_next;
    logic                         sub;

    // top multiplier bit carries negative weight
    assign sub = neg_reg ^ (cnt_reg == m4inv_pkg::MCW'(m4inv_pkg::EW - 1));

    always_comb
    begin
        busy_next  = busy_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        mcand_next = mcand_reg;
        y_next     = y_reg;
        neg_next   = neg_reg;
        if (cmd.start)
        begin
            busy_next  = 1'b1;
            cnt_next   = '0;
            acc_next   = cmd.keep ? acc_reg : init;
            mcand_next = x;
            y_next     = y;
            neg_next   = cmd.neg;
        end
        else if (busy_reg)
        begin
            if (y_reg[0])
            begin
                acc_next = sub ? (acc_reg + ~mcand_reg + m4inv_pkg::AW'(1))
                               : (acc_reg + mcand_reg);
            end
            mcand_next = {mcand_reg[m4inv_pkg::AW-2:0], 1'b0};
            y_next     = {1'b0, y_reg[m4inv_pkg::EW-1:1]};
            cnt_next   = cnt_reg + m4inv_pkg::MCW'(1);
            if (cnt_reg == m4inv_pkg::MCW'(m4inv_pkg::EW - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        mcand_reg <= mcand_next;
        y_reg     <= y_next;
        neg_reg   <= neg_next;
    end

    assign busy = busy_reg;
    assign acc  = acc_reg;
endmodule
`default_nettype wire

>>> sv/m4inv_div.sv
// Restoring divider: overflow check, then one quotient bit per cycle.
`default_nettype none
module m4inv_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [m4inv_pkg::NW-1:0]    num,
    input  wire logic [m4inv_pkg::AW-1:0]    den,
    output logic                             busy,
    output logic                             big,
    output logic      [m4inv_pkg::QW-1:0]    quot
);
    logic                         busy_reg, busy_next;
    logic [m4inv_pkg::DCW-1:0]    cnt_reg, cnt_next;
    logic [m4inv_pkg::AW-1:0]     rem_reg, rem_next;
    logic [m4inv_pkg::QW-1:0]     nlow_reg, nlow_next;
    logic [m4inv_pkg::QW-1:0]     quot_reg, quot_next;
    logic                         big_reg, big_next;
    logic [m4inv_pkg::AW-1:0]     num_hi;
    logic [m4inv_pkg::AW:0]       trial;
    logic [m4inv_pkg::AW:0]       diff;
    logic                         ge;

    assign num_hi = {{(m4inv_pkg::AW - m4inv_pkg::NHW){1'b0}},
                     num[m4inv_pkg::NW-1:m4inv_pkg::QW]};
    assign trial  = {rem_reg, nlow_reg[m4inv_pkg::QW-1]};
    assign diff   = trial - {1'b0, den};
    assign ge     = (trial >= {1'b0, den});

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        nlow_next = nlow_reg;
        quot_next = quot_reg;
        big_next  = big_reg;
        if (start)
        begin
            // quotient needs more than QW bits exactly when this holds
            big_next  = (num_hi >= den);
            rem_next  = num_hi;
            nlow_next = num[m4inv_pkg::QW-1:0];
            quot_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? diff[m4inv_pkg::AW-1:0] : trial[m4inv_pkg::AW-1:0];
            nlow_next = {nlow_reg[m4inv_pkg::QW-2:0], 1'b0};
            quot_next = {quot_reg[m4inv_pkg::QW-2:0], ge};
            cnt_next  = cnt_reg + m4inv_pkg::DCW'(1);
            if (cnt_reg == m4inv_pkg::DCW'(m4inv_pkg::QW - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        nlow_reg <= nlow_next;
        quot_reg <= quot_next;
        big_reg  <= big_next;
    end

    assign busy = busy_reg;
    assign big  = big_reg;
    assign quot = quot_reg;
endmodule
`default_nettype wire

>>> sv/matrix4_inverse_unit.sv
// Top level of the 4x4 matrix inverse unit: sequencer, stores and result register.
// A 4x4 matrix in signed Q16.16 is loaded one element per load transaction, by
// column-major index (column*4 + row). A load with start_inverse set stores
// its element and then runs the inversion, during which load_ready is low. The
// run forms the sixteen cofactors exactly on one shared bit-serial
// multiply-accumulate unit (nine products per cofactor), takes the determinant
// from the first column (four more products), then produces each inverse
// element as adj*2^32/det on a restoring divider at one quotient bit per cycle.
// A stall on the result channel holds the run. Results leave through a
// one-entry output register in index order 0..15, last_result marking the
// sixteenth; quotients are truncated toward zero and clipped to 32 bits with
// saturated set. A zero determinant gives sixteen zero results with singular
// set. Reading an element never loaded since reset gives undefined results.
`default_nettype none
`include "matrix4_inverse_unit_assert.svh"
module matrix4_inverse_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               load_valid,
    output logic                    load_ready,
    input  wire m4inv_pkg::load_t   load_data,
    output logic                    result_valid,
    input  wire logic               result_ready,
    output m4inv_pkg::result_t      result_data
);
    m4inv_pkg::state_t state_reg, state_next;

    logic [m4inv_pkg::IW-1:0]  k_reg, k_next;       // cofactor / row / output index
    logic [1:0]                j_reg, j_next;       // expansion term
    logic [1:0]                m_reg, m_next;       // step within a term
    logic                      det_reg, det_next;   // determinant phase
    logic [m4inv_pkg::CW-1:0]  part_reg, part_next; // partial cofactor
    logic [m4inv_pkg::AW-1:0]  x_reg, x_next;
    logic                      sing_reg, sing_next;
    logic                      dneg_reg, dneg_next;
    logic [m4inv_pkg::AW-1:0]  dmag_reg, dmag_next;
    logic                      neg_reg, neg_next;
    logic                      rv_reg, rv_next;
    m4inv_pkg::result_t        rd_reg, rd_next;

    logic                      load_fire;
    logic                      emit_fire;

    logic                      mat_we;
    logic [m4inv_pkg::IW-1:0]  mat_raddr;
    logic [m4inv_pkg::EW-1:0]  mat_rdata;
    logic                      cof_we;
    logic [m4inv_pkg::IW-1:0]  cof_raddr;
    logic [m4inv_pkg::CW-1:0]  cof_rdata;

    m4inv_pkg::mac_cmd_t       mac_cmd;
    logic [m4inv_pkg::AW-1:0]  mac_init;
    logic                      mac_busy;
    logic [m4inv_pkg::AW-1:0]  mac_acc;

    logic                      div_start;
    logic [m4inv_pkg::NW-1:0]  div_num;
    logic                      div_busy;
    logic                      div_big;
    logic [m4inv_pkg::QW-1:0]  div_quot;

    logic [1:0]                row_k, col_k, col_p, col_q;
    logic [m4inv_pkg::IW-1:0]  x_addr, y_addr;
    logic [m4inv_pkg::CW-2:0]  cof_mag;

    // index of the i-th entry of {0..3} with x removed
    function automatic logic [1:0] skip(input logic [1:0] i, input logic [1:0] x);
        skip = (i < x) ? i : i + 2'd1;
    endfunction

    assign row_k = k_reg[3:2];
    assign col_k = k_reg[1:0];
    // the two columns of the minor used by term j
    assign col_p = (j_reg == 2'd0) ? 2'd1 : 2'd0;
    assign col_q = (j_reg == 2'd2) ? 2'd1 : 2'd2;

    always_comb
    begin
        x_addr = '0;
        y_addr = '0;
        if (det_reg)
        begin
            y_addr = {2'b00, k_reg[1:0]};
        end
        else
        begin
            case (m_reg)
                2'd0:
                begin
                    x_addr = {skip(col_p, col_k), skip(2'd1, row_k)};
                    y_addr = {skip(col_q, col_k), skip(2'd2, row_k)};
                end
                2'd1:
                begin
                    x_addr = {skip(col_q, col_k), skip(2'd1, row_k)};
                    y_addr = {skip(col_p, col_k), skip(2'd2, row_k)};
                end
                default:
                begin
                    y_addr = {skip(j_reg, col_k), skip(2'd0, row_k)};
                end
            endcase
        end
    end

    assign load_fire = load_valid && load_ready;
    assign emit_fire = (state_reg == m4inv_pkg::ST_EMIT) && (!rv_reg || result_ready);
    assign cof_mag   = cof_rdata[m4inv_pkg::CW-1]
                       ? (~cof_rdata[m4inv_pkg::CW-2:0] + (m4inv_pkg::CW-1)'(1))
                       : cof_rdata[m4inv_pkg::CW-2:0];
    assign div_num   = {cof_mag, {(2 * m4inv_pkg::FRAC_BITS){1'b0}}};

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            m4inv_pkg::ST_IDLE:
            begin
                if (load_fire && load_data.start_inverse)
                begin
                    state_next = m4inv_pkg::ST_RD_X;
                end
            end
            m4inv_pkg::ST_RD_X:    state_next = m4inv_pkg::ST_RD_Y;
            m4inv_pkg::ST_RD_Y:    state_next = m4inv_pkg::ST_LD_Y;
            m4inv_pkg::ST_LD_Y:    state_next = m4inv_pkg::ST_MUL;
            m4inv_pkg::ST_MUL:
            begin
                if (!mac_busy)
                begin
                    state_next = (det_reg && (k_reg[1:0] == 2'd3))
                                 ? m4inv_pkg::ST_DET_CHK : m4inv_pkg::ST_RD_X;
                end
            end
            m4inv_pkg::ST_DET_CHK: state_next = m4inv_pkg::ST_DIV_RD;
            m4inv_pkg::ST_DIV_RD:  state_next = m4inv_pkg::ST_DIV_GO;
            m4inv_pkg::ST_DIV_GO:
            begin
                state_next = sing_reg ? m4inv_pkg::ST_EMIT : m4inv_pkg::ST_DIV_RUN;
            end
            m4inv_pkg::ST_DIV_RUN:
            begin
                if (!div_busy)
                begin
                    state_next = m4inv_pkg::ST_EMIT;
                end
            end
            m4inv_pkg::ST_EMIT:
            begin
                if (emit_fire)
                begin
                    state_next = (k_reg == m4inv_pkg::IW'(15))
                                 ? m4inv_pkg::ST_IDLE : m4inv_pkg::ST_DIV_RD;
                end
            end
            default:               state_next = m4inv_pkg::ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        k_next    = k_reg;
        j_next    = j_reg;
        m_next    = m_reg;
        det_next  = det_reg;
        part_next = part_reg;
        x_next    = x_reg;
        sing_next = sing_reg;
        dneg_next = dneg_reg;
        dmag_next = dmag_reg;
        neg_next  = neg_reg;
        rv_next   = rv_reg && !result_ready;
        rd_next   = rd_reg;
        load_ready = (state_reg == m4inv_pkg::ST_IDLE);
        mat_we    = load_fire;
        mat_raddr = '0;
        cof_we    = 1'b0;
        cof_raddr = '0;
        mac_cmd   = '0;
        mac_init  = '0;
        div_start = 1'b0;

        case (state_reg)
            m4inv_pkg::ST_IDLE:
            begin
                if (load_fire && load_data.start_inverse)
                begin
                    k_next   = '0;
                    j_next   = '0;
                    m_next   = '0;
                    det_next = 1'b0;
                end
            end
            m4inv_pkg::ST_RD_X:
            begin
                mat_raddr = x_addr;
                cof_raddr = {k_reg[1:0], 2'b00};
            end
            m4inv_pkg::ST_RD_Y:
            begin
                mat_raddr = y_addr;
                if (det_reg)
                begin
                    x_next = {{(m4inv_pkg::AW - m4inv_pkg::CW){cof_rdata[m4inv_pkg::CW-1]}},
                              cof_rdata};
                end
                else if (m_reg == 2'd2)
                begin
                    x_next = mac_acc;   // the 2x2 minor just formed
                end
                else
                begin
                    x_next = {{(m4inv_pkg::AW - m4inv_pkg::EW){mat_rdata[m4inv_pkg::EW-1]}},
                              mat_rdata};
                end
            end
            m4inv_pkg::ST_LD_Y:
            begin
                mac_cmd.start = 1'b1;
                if (det_reg)
                begin
                    mac_cmd.keep = (k_reg[1:0] != 2'd0);
                end
                else
                begin
                    mac_cmd.keep = (m_reg == 2'd1);
                    mac_cmd.neg  = (m_reg == 2'd1) ||
                                   ((m_reg == 2'd2) && ((j_reg == 2'd1) ^ k_reg[2] ^ k_reg[0]));
                    if ((m_reg == 2'd2) && (j_reg != 2'd0))
                    begin
                        mac_init = {{(m4inv_pkg::AW - m4inv_pkg::CW){part_reg[m4inv_pkg::CW-1]}},
                                    part_reg};
                    end
                end
            end
            m4inv_pkg::ST_MUL:
            begin
                if (!mac_busy)
                begin
                    if (det_reg)
                    begin
                        k_next = (k_reg[1:0] == 2'd3) ? '0 : k_reg + m4inv_pkg::IW'(1);
                    end
                    else if (m_reg != 2'd2)
                    begin
                        m_next = m_reg + 2'd1;
                    end
                    else
                    begin
                        part_next = mac_acc[m4inv_pkg::CW-1:0];
                        m_next    = '0;
                        if (j_reg != 2'd2)
                        begin
                            j_next = j_reg + 2'd1;
                        end
                        else
                        begin
                            j_next = '0;
                            cof_we = 1'b1;
                            k_next = k_reg + m4inv_pkg::IW'(1);
                            if (k_reg == m4inv_pkg::IW'(15))
                            begin
                                det_next = 1'b1;
                            end
                        end
                    end
                end
            end
            m4inv_pkg::ST_DET_CHK:
            begin
                sing_next = (mac_acc == '0);
                dneg_next = mac_acc[m4inv_pkg::AW-1];
                dmag_next = mac_acc[m4inv_pkg::AW-1] ? (~mac_acc + m4inv_pkg::AW'(1)) : mac_acc;
            end
            m4inv_pkg::ST_DIV_RD:
            begin
                cof_raddr = k_reg;
            end
            m4inv_pkg::ST_DIV_GO:
            begin
                div_start = !sing_reg;
                neg_next  = cof_rdata[m4inv_pkg::CW-1] ^ dneg_reg;
            end
            m4inv_pkg::ST_DIV_RUN:
            begin
            end
            m4inv_pkg::ST_EMIT:
            begin
                if (emit_fire)
                begin
                    rv_next = 1'b1;
                    rd_next.result_index = k_reg;
                    rd_next.singular     = sing_reg;
                    rd_next.last_result  = (k_reg == m4inv_pkg::IW'(15));
                    rd_next.saturated    = 1'b0;
                    rd_next.result_value = '0;
                    if (!sing_reg)
                    begin
                        if (!neg_reg)
                        begin
                            if (div_big || div_quot[32] || div_quot[31])
                            begin
                                rd_next.result_value = 32'sh7FFF_FFFF;
                                rd_next.saturated    = 1'b1;
                            end
                            else
                            begin
                                rd_next.result_value = div_quot[31:0];
                            end
                        end
                        else if (div_big || div_quot[32] ||
                                 (div_quot[31] && (div_quot[30:0] != '0)))
                        begin
                            rd_next.result_value = 32'sh8000_0000;
                            rd_next.saturated    = 1'b1;
                        end
                        else
                        begin
                            rd_next.result_value = ~div_quot[31:0] + 32'd1;
                        end
                    end
                    k_next = k_reg + m4inv_pkg::IW'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= m4inv_pkg::ST_IDLE;
            k_reg     <= '0;
            j_reg     <= '0;
            m_reg     <= '0;
            det_reg   <= 1'b0;
            sing_reg  <= 1'b0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            j_reg     <= j_next;
            m_reg     <= m_next;
            det_reg   <= det_next;
            sing_reg  <= sing_next;
            rv_reg    <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        part_reg <= part_next;
        x_reg    <= x_next;
        dneg_reg <= dneg_next;
        dmag_reg <= dmag_next;
        neg_reg  <= neg_next;
        rd_reg   <= rd_next;
    end

    m4inv_ram #(
        .WIDTH (m4inv_pkg::EW),
        .DEPTH (16)
    ) u_mat_ram (
        .clk   (clk),
        .we    (mat_we),
        .waddr (load_data.load_index),
        .wdata (load_data.load_value),
        .raddr (mat_raddr),
        .rdata (mat_rdata)
    );

    // entry k holds the adjugate element for output index k
    m4inv_ram #(
        .WIDTH (m4inv_pkg::CW),
        .DEPTH (16)
    ) u_cof_ram (
        .clk   (clk),
        .we    (cof_we),
        .waddr (k_reg),
        .wdata (mac_acc[m4inv_pkg::CW-1:0]),
        .raddr (cof_raddr),
        .rdata (cof_rdata)
    );

    m4inv_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (mac_cmd),
        .x     (x_reg),
        .y     (mat_rdata),
        .init  (mac_init),
        .busy  (mac_busy),
        .acc   (mac_acc)
    );

    m4inv_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (dmag_reg),
        .busy  (div_busy),
        .big   (div_big),
        .quot  (div_quot)
    );

    assign result_valid = rv_reg;
    assign result_data  = rd_reg;

    // a singular run carries zero, unsaturated values
    `M4INV_ASSERT_IMPLY(a_sing_zero, clk, rst_n, result_valid && result_data.singular,
        (result_data.result_value == '0) && !result_data.saturated)
    // the multiply unit is only started when idle
    `M4INV_ASSERT_IMPLY(a_mac_free, clk, rst_n, mac_cmd.start, !mac_busy)
    // no division is issued for a zero determinant
    `M4INV_ASSERT_IMPLY(a_div_nonsing, clk, rst_n, div_start, !sing_reg && !div_busy)
    // a start transaction closes the load channel until the run ends
    `M4INV_ASSERT_NEXT(a_start_blocks, clk, rst_n,
        load_valid && load_ready && load_data.start_inverse, !load_ready)
endmodule
`default_nettype wire
